[rtl/assert_macros.svh]
// Assertion macros used by the complex arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define CAU_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define CAU_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/cau_pkg.sv]
// Shared opcodes, status codes and pipeline control types of the complex arithmetic unit.
package cau_pkg;

   typedef enum logic [4:0] {
      OP_NEG  = 5'd0,
      OP_INC  = 5'd1,
      OP_DEC  = 5'd2,
      OP_ADD  = 5'd3,
      OP_SUB  = 5'd4,
      OP_MUL  = 5'd5,
      OP_DIV  = 5'd6,
      OP_EQ   = 5'd7,
      OP_NE   = 5'd8,
      OP_LT   = 5'd9,
      OP_LE   = 5'd10,
      OP_GT   = 5'd11,
      OP_GE   = 5'd12,
      OP_SADD = 5'd13,
      OP_SSUB = 5'd14,
      OP_SMUL = 5'd15,
      OP_SDIV = 5'd16
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_SAT      = 2'd2
   } status_type;

   // how a result lane is finished
   typedef enum logic [1:0] {
      K_ZERO   = 2'd0,
      K_PLAIN  = 2'd1,
      K_SCALED = 2'd2,
      K_DIV    = 2'd3
   } kind_type;

   typedef struct packed {
      logic       valid;
      logic       is_div;
      logic       neg_re;
      logic       neg_im;
      logic       ovf_re;
      logic       ovf_im;
      logic       truth;
      status_type status;
   } ctrl_type;

endpackage

[rtl/cau_div_cell.sv]
// One restoring-division cell: develops one quotient bit per lane and hands on to the next cell.
module cau_div_cell #(
   parameter int W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  cau_pkg::ctrl_type prev_ctrl,
   input  logic [2*W-1:0]    prev_den,
   input  logic [2*W-1:0]    prev_rem_re,
   input  logic [W-1:0]      prev_qx_re,
   input  logic [2*W-1:0]    prev_rem_im,
   input  logic [W-1:0]      prev_qx_im,
   output cau_pkg::ctrl_type next_ctrl,
   output logic [2*W-1:0]    next_den,
   output logic [2*W-1:0]    next_rem_re,
   output logic [W-1:0]      next_qx_re,
   output logic [2*W-1:0]    next_rem_im,
   output logic [W-1:0]      next_qx_im
);

   localparam int DW = 2 * W;

   cau_pkg::ctrl_type ctrl_ff;
   logic [DW-1:0]     den_ff;
   logic [DW-1:0]     rem_re_ff, rem_re_in, rem_im_ff, rem_im_in;
   logic [W-1:0]      qx_re_ff, qx_re_in, qx_im_ff, qx_im_in;

   // qx holds the dividend bits still to come on top, quotient bits below
   function automatic logic [DW+W-1:0] step_fn(input logic [DW-1:0] rem,
                                               input logic [W-1:0] qx,
                                               input logic [DW-1:0] den);
      logic [DW:0]   t;
      logic          ge;
      logic [DW-1:0] r;
      t  = {rem, qx[W-1]};
      ge = (t >= {1'b0, den});
      r  = ge ? DW'(t - {1'b0, den}) : t[DW-1:0];
      return {r, qx[W-2:0], ge};
   endfunction

   always_comb begin
      if (prev_ctrl.is_div) begin
         {rem_re_in, qx_re_in} = step_fn(prev_rem_re, prev_qx_re, prev_den);
         {rem_im_in, qx_im_in} = step_fn(prev_rem_im, prev_qx_im, prev_den);
      end else begin
         rem_re_in = prev_rem_re;
         qx_re_in  = prev_qx_re;
         rem_im_in = prev_rem_im;
         qx_im_in  = prev_qx_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= prev_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      den_ff    <= prev_den;
      rem_re_ff <= rem_re_in;
      qx_re_ff  <= qx_re_in;
      rem_im_ff <= rem_im_in;
      qx_im_ff  <= qx_im_in;
   end

   assign next_ctrl   = ctrl_ff;
   assign next_den    = den_ff;
   assign next_rem_re = rem_re_ff;
   assign next_qx_re  = qx_re_ff;
   assign next_rem_im = rem_im_ff;
   assign next_qx_im  = qx_im_ff;

endmodule

[rtl/complex_arithmetic_unit.sv]
// Complex arithmetic unit top level: product, sum and prep stages, division cell chain, output.
//
// Takes one transaction every clock cycle (busy never rises) and returns its result through the
// product, sum and prep registers, the division chain and the output register, strobed by
// rsp_valid for one cycle; results leave in request order and cannot be held off. The chain has
// one cell per quotient bit; every operation travels the same chain so that ordering is kept.
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [4:0]                   req_type,
   input  logic signed [DATA_WIDTH-1:0] req_a_re,
   input  logic signed [DATA_WIDTH-1:0] req_a_im,
   input  logic signed [DATA_WIDTH-1:0] req_b_re,
   input  logic signed [DATA_WIDTH-1:0] req_b_im,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_res_re,
   output logic signed [DATA_WIDTH-1:0] rsp_res_im,
   output logic                         rsp_truth,
   output logic [1:0]                   rsp_status
);

`include "assert_macros.svh"

   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int PW = 2 * W;
   localparam int MW = 2 * W + 1;
   localparam int DW = 2 * W;
   localparam int XW = MW + F;
   localparam int TW = XW - W;
   localparam int CW = (TW > DW) ? TW : DW;

   localparam logic signed [PW-1:0] ONE_P = PW'(1) << F;
   localparam logic [MW-1:0]        MAXP  = (MW'(1) << (W - 1)) - MW'(1);
   localparam logic [MW-1:0]        MAXN  = MW'(1) << (W - 1);
   localparam logic [W-1:0]         MAX_V = {1'b0, {(W - 1){1'b1}}};
   localparam logic [W-1:0]         MIN_V = {1'b1, {(W - 1){1'b0}}};

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // ---------------- stage 1: operands and products
   logic                  valid1_ff;
   cau_pkg::op_type       op1_ff;
   logic signed [W-1:0]   ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic signed [PW-1:0]  p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff;
   logic signed [PW-1:0]  sq_ar_ff, sq_ai_ff, sq_br_ff, sq_bi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff   <= cau_pkg::op_type'(req_type);
      ar1_ff   <= req_a_re;
      ai1_ff   <= req_a_im;
      br1_ff   <= req_b_re;
      bi1_ff   <= req_b_im;
      p_rr_ff  <= PW'(req_a_re) * PW'(req_b_re);
      p_ii_ff  <= PW'(req_a_im) * PW'(req_b_im);
      p_ir_ff  <= PW'(req_a_im) * PW'(req_b_re);
      p_ri_ff  <= PW'(req_a_re) * PW'(req_b_im);
      sq_ar_ff <= PW'(req_a_re) * PW'(req_a_re);
      sq_ai_ff <= PW'(req_a_im) * PW'(req_a_im);
      sq_br_ff <= PW'(req_b_re) * PW'(req_b_re);
      sq_bi_ff <= PW'(req_b_im) * PW'(req_b_im);
   end

   // ---------------- stage 2: signed sums to sign-magnitude, comparisons, divisor
   logic signed [PW-1:0] xr, yr, xi, yi;
   logic                 sub_re, sub_im, flip;
   cau_pkg::kind_type    kind;
   logic signed [MW-1:0] s_re, ns_re, s_im, ns_im;
   logic [MW-1:0]        m_a, m_b, den_sum;
   logic [W-1:0]         br_abs;
   logic                 eq, lt, gt, truth_c;
   logic [DW-1:0]        den_c;

   logic                 valid2_ff;
   cau_pkg::kind_type    kind2_ff;
   logic                 neg_re2_ff, neg_im2_ff, truth2_ff;
   logic [MW-1:0]        mag_re2_ff, mag_im2_ff;
   logic [DW-1:0]        den2_ff;

   always_comb begin
      xr     = PW'(ar1_ff);
      yr     = PW'(br1_ff);
      xi     = PW'(ai1_ff);
      yi     = PW'(bi1_ff);
      sub_re = 1'b0;
      sub_im = 1'b0;
      flip   = 1'b0;
      kind   = cau_pkg::K_ZERO;
      unique case (op1_ff)
         cau_pkg::OP_NEG: begin
            xr = '0; yr = PW'(ar1_ff); xi = '0; yi = PW'(ai1_ff);
            sub_re = 1'b1; sub_im = 1'b1; kind = cau_pkg::K_PLAIN;
         end
         cau_pkg::OP_INC: begin
            yr = ONE_P; yi = '0; kind = cau_pkg::K_PLAIN;
         end
         cau_pkg::OP_DEC: begin
            yr = ONE_P; yi = '0; sub_re = 1'b1; kind = cau_pkg::K_PLAIN;
         end
         cau_pkg::OP_ADD: kind = cau_pkg::K_PLAIN;
         cau_pkg::OP_SUB: begin
            sub_re = 1'b1; sub_im = 1'b1; kind = cau_pkg::K_PLAIN;
         end
         cau_pkg::OP_MUL: begin
            xr = p_rr_ff; yr = p_ii_ff; sub_re = 1'b1;
            xi = p_ir_ff; yi = p_ri_ff; kind = cau_pkg::K_SCALED;
         end
         cau_pkg::OP_DIV: begin
            xr = p_rr_ff; yr = p_ii_ff;
            xi = p_ir_ff; yi = p_ri_ff; sub_im = 1'b1; kind = cau_pkg::K_DIV;
         end
         cau_pkg::OP_SADD: begin
            yi = '0; kind = cau_pkg::K_PLAIN;
         end
         cau_pkg::OP_SSUB: begin
            yi = '0; sub_re = 1'b1; kind = cau_pkg::K_PLAIN;
         end
         cau_pkg::OP_SMUL: begin
            xr = p_rr_ff; yr = '0; xi = p_ir_ff; yi = '0; kind = cau_pkg::K_SCALED;
         end
         cau_pkg::OP_SDIV: begin
            yr = '0; yi = '0; flip = br1_ff[W-1]; kind = cau_pkg::K_DIV;
         end
         default: kind = cau_pkg::K_ZERO;
      endcase
   end

   always_comb begin
      // the negated sum is formed in parallel rather than after the add
      s_re  = sub_re ? (MW'(xr) - MW'(yr)) : (MW'(xr) + MW'(yr));
      ns_re = sub_re ? (MW'(yr) - MW'(xr)) : (-MW'(xr) - MW'(yr));
      s_im  = sub_im ? (MW'(xi) - MW'(yi)) : (MW'(xi) + MW'(yi));
      ns_im = sub_im ? (MW'(yi) - MW'(xi)) : (-MW'(xi) - MW'(yi));

      m_a     = {1'b0, sq_ar_ff} + {1'b0, sq_ai_ff};
      m_b     = {1'b0, sq_br_ff} + {1'b0, sq_bi_ff};
      den_sum = m_b;
      eq      = (ar1_ff == br1_ff) && (ai1_ff == bi1_ff);
      lt      = m_a < m_b;
      gt      = m_a > m_b;
      br_abs  = br1_ff[W-1] ? W'(-br1_ff) : br1_ff;

      case (op1_ff)
         cau_pkg::OP_EQ: truth_c = eq;
         cau_pkg::OP_NE: truth_c = !eq;
         cau_pkg::OP_LT: truth_c = lt;
         cau_pkg::OP_LE: truth_c = lt || eq;
         cau_pkg::OP_GT: truth_c = gt;
         cau_pkg::OP_GE: truth_c = gt || eq;
         default:        truth_c = 1'b0;
      endcase

      den_c = (op1_ff == cau_pkg::OP_SDIV) ? DW'(br_abs) : den_sum[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      kind2_ff   <= kind;
      neg_re2_ff <= s_re[MW-1] ^ flip;
      neg_im2_ff <= s_im[MW-1] ^ flip;
      mag_re2_ff <= s_re[MW-1] ? ns_re : s_re;
      mag_im2_ff <= s_im[MW-1] ? ns_im : s_im;
      truth2_ff  <= truth_c;
      den2_ff    <= den_c;
   end

   // ---------------- stage 3: clamp plain results, prepare division
   function automatic logic [W:0] clamp_fn(input logic neg, input logic [MW-1:0] q);
      logic         sat;
      logic [W-1:0] v;
      sat = neg ? (q > MAXN) : (q > MAXP);
      if (sat) begin
         v = neg ? MIN_V : MAX_V;
      end else begin
         v = neg ? (-q[W-1:0]) : q[W-1:0];
      end
      return {sat, v};
   endfunction

   logic [MW-1:0]     q_re, q_im;
   logic [W:0]        cl_re, cl_im;
   logic [XW-1:0]     x_re, x_im;
   logic [TW-1:0]     t_re, t_im;
   logic              ovf_re, ovf_im, dz, is_div, zero_res;
   cau_pkg::ctrl_type ctrl_c;
   logic [DW-1:0]     rem_re_c, rem_im_c;
   logic [W-1:0]      qx_re_c, qx_im_c;

   always_comb begin
      q_re   = (kind2_ff == cau_pkg::K_SCALED) ? (mag_re2_ff >> F) : mag_re2_ff;
      q_im   = (kind2_ff == cau_pkg::K_SCALED) ? (mag_im2_ff >> F) : mag_im2_ff;
      cl_re  = clamp_fn(neg_re2_ff, q_re);
      cl_im  = clamp_fn(neg_im2_ff, q_im);
      x_re   = XW'(mag_re2_ff) << F;
      x_im   = XW'(mag_im2_ff) << F;
      t_re   = x_re[XW-1:W];
      t_im   = x_im[XW-1:W];
      ovf_re = CW'(t_re) >= CW'(den2_ff);
      ovf_im = CW'(t_im) >= CW'(den2_ff);
      dz     = (kind2_ff == cau_pkg::K_DIV) && (den2_ff == '0);
      is_div = (kind2_ff == cau_pkg::K_DIV) && !dz;
      zero_res = (kind2_ff == cau_pkg::K_ZERO) || dz;

      ctrl_c.valid  = valid2_ff;
      ctrl_c.is_div = is_div;
      ctrl_c.neg_re = neg_re2_ff;
      ctrl_c.neg_im = neg_im2_ff;
      ctrl_c.ovf_re = ovf_re;
      ctrl_c.ovf_im = ovf_im;
      ctrl_c.truth  = truth2_ff;
      if (dz) begin
         ctrl_c.status = cau_pkg::ST_DIV_ZERO;
      end else if (!zero_res && !is_div && (cl_re[W] || cl_im[W])) begin
         ctrl_c.status = cau_pkg::ST_SAT;
      end else begin
         ctrl_c.status = cau_pkg::ST_OK;
      end

      rem_re_c = ovf_re ? '0 : DW'(t_re);
      rem_im_c = ovf_im ? '0 : DW'(t_im);
      if (is_div) begin
         qx_re_c = x_re[W-1:0];
         qx_im_c = x_im[W-1:0];
      end else if (zero_res) begin
         qx_re_c = '0;
         qx_im_c = '0;
      end else begin
         qx_re_c = cl_re[W-1:0];
         qx_im_c = cl_im[W-1:0];
      end
   end

   cau_pkg::ctrl_type ctrl3_ff;
   logic [DW-1:0]     den3_ff, rem_re3_ff, rem_im3_ff;
   logic [W-1:0]      qx_re3_ff, qx_im3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl3_ff <= '0;
      end else begin
         ctrl3_ff <= ctrl_c;
      end
   end

   always_ff @(posedge clock) begin
      den3_ff    <= den2_ff;
      rem_re3_ff <= rem_re_c;
      rem_im3_ff <= rem_im_c;
      qx_re3_ff  <= qx_re_c;
      qx_im3_ff  <= qx_im_c;
   end

   // ---------------- division chain, one quotient bit per cell
   cau_pkg::ctrl_type chain_ctrl   [0:W];
   logic [DW-1:0]     chain_den    [0:W];
   logic [DW-1:0]     chain_rem_re [0:W];
   logic [DW-1:0]     chain_rem_im [0:W];
   logic [W-1:0]      chain_qx_re  [0:W];
   logic [W-1:0]      chain_qx_im  [0:W];

   assign chain_ctrl[0]   = ctrl3_ff;
   assign chain_den[0]    = den3_ff;
   assign chain_rem_re[0] = rem_re3_ff;
   assign chain_rem_im[0] = rem_im3_ff;
   assign chain_qx_re[0]  = qx_re3_ff;
   assign chain_qx_im[0]  = qx_im3_ff;

   for (genvar k = 0; k < W; k++) begin : g_cell
      cau_div_cell #(
         .W (W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .prev_ctrl   (chain_ctrl[k]),
         .prev_den    (chain_den[k]),
         .prev_rem_re (chain_rem_re[k]),
         .prev_qx_re  (chain_qx_re[k]),
         .prev_rem_im (chain_rem_im[k]),
         .prev_qx_im  (chain_qx_im[k]),
         .next_ctrl   (chain_ctrl[k+1]),
         .next_den    (chain_den[k+1]),
         .next_rem_re (chain_rem_re[k+1]),
         .next_qx_re  (chain_qx_re[k+1]),
         .next_rem_im (chain_rem_im[k+1]),
         .next_qx_im  (chain_qx_im[k+1])
      );
   end

   // ---------------- output stage
   cau_pkg::ctrl_type tail;
   logic [MW-1:0]     dq_re, dq_im;
   logic [W:0]        dcl_re, dcl_im;
   logic [W-1:0]      res_re_in, res_im_in;
   logic [1:0]        status_in;

   logic              valid_ff, truth_ff;
   logic [W-1:0]      res_re_ff, res_im_ff;
   logic [1:0]        status_ff;

   always_comb begin
      tail = chain_ctrl[W];
      // an overflowed quotient is pushed past every bound so that it saturates
      dq_re  = MW'(chain_qx_re[W]) | (MW'(tail.ovf_re) << W);
      dq_im  = MW'(chain_qx_im[W]) | (MW'(tail.ovf_im) << W);
      dcl_re = clamp_fn(tail.neg_re, dq_re);
      dcl_im = clamp_fn(tail.neg_im, dq_im);
      if (tail.is_div) begin
         res_re_in = dcl_re[W-1:0];
         res_im_in = dcl_im[W-1:0];
         status_in = (dcl_re[W] || dcl_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end else begin
         res_re_in = chain_qx_re[W];
         res_im_in = chain_qx_im[W];
         status_in = tail.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      res_re_ff <= res_re_in;
      res_im_ff <= res_im_in;
      truth_ff  <= tail.truth;
      status_ff <= status_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_res_re = res_re_ff;
   assign rsp_res_im = res_im_ff;
   assign rsp_truth  = truth_ff;
   assign rsp_status = status_ff;

   // ---------------- checks
   `CAU_ASSERT(a_dz_zero, clock, reset, rsp_valid && (rsp_status == cau_pkg::ST_DIV_ZERO) |-> (rsp_res_re == '0) && (rsp_res_im == '0) && !rsp_truth, "divide by zero result not cleared")
   `CAU_ASSERT(a_truth_clean, clock, reset, rsp_valid && rsp_truth |-> (rsp_status == cau_pkg::ST_OK) && (rsp_res_re == '0) && (rsp_res_im == '0), "comparison result carries data")
   `CAU_ASSERT(a_status_code, clock, reset, rsp_valid |-> (rsp_status == cau_pkg::ST_OK) || (rsp_status == cau_pkg::ST_DIV_ZERO) || (rsp_status == cau_pkg::ST_SAT), "undefined status code")
   `CAU_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid, "result strobe right after reset")

endmodule

[bench/complex_arithmetic_unit_tb.sv]
// Self-checking testbench for the complex arithmetic unit: random and directed operations.
`timescale 1ns / 100ps

module complex_arithmetic_unit_tb;

   localparam int WDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 60;
   localparam logic [4:0] UNUSED_OP = 5'd31;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [4:0]         op;
      logic signed [31:0] a_re, a_im, b_re, b_im;
   } operation_type;

   typedef struct {
      logic signed [31:0] re, im;
      logic               truth;
      logic [1:0]         status;
   } outcome_type;

   logic clock, reset, start, busy;
   logic [4:0] req_type;
   logic signed [31:0] req_a_re, req_a_im, req_b_re, req_b_im;
   logic rsp_valid, rsp_truth;
   logic signed [31:0] rsp_res_re, rsp_res_im;
   logic [1:0] rsp_status;

   operation_type pending_ops[$];
   outcome_type   expected_outcomes[$];
   int errors = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;

   complex_arithmetic_unit dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // clamp a sign/magnitude value into 32 bits; bit 32 flags saturation
   function automatic logic [32:0] fit_part(logic neg, logic [127:0] mag);
      if (!neg) begin
         if (mag > 128'h7fffffff) return {1'b1, 32'h7fffffff};
         return {1'b0, mag[31:0]};
      end
      if (mag > 128'h80000000) return {1'b1, 32'h80000000};
      return {1'b0, -mag[31:0]};
   endfunction

   function automatic logic [127:0] mag_of(wide_type v);
      return v < 0 ? -v : v;
   endfunction

   function automatic outcome_type compute_outcome(operation_type t);
      wide_type ar, ai, br, bi, p, q, den, m1, m2;
      logic [32:0] fr, fi;
      outcome_type r;
      logic eq;
      ar = t.a_re; ai = t.a_im; br = t.b_re; bi = t.b_im;
      r = '{re: 0, im: 0, truth: 0, status: cau_pkg::ST_OK};
      fr = '0; fi = '0;
      eq = (ar == br) && (ai == bi);
      m1 = ar * ar + ai * ai;
      m2 = br * br + bi * bi;
      case (t.op)
         cau_pkg::OP_NEG: begin
            fr = fit_part(ar > 0, mag_of(ar));
            fi = fit_part(ai > 0, mag_of(ai));
         end
         cau_pkg::OP_INC, cau_pkg::OP_DEC, cau_pkg::OP_ADD, cau_pkg::OP_SUB,
         cau_pkg::OP_SADD, cau_pkg::OP_SSUB: begin
            case (t.op)
               cau_pkg::OP_INC: begin p = ar + 65536; q = ai; end
               cau_pkg::OP_DEC: begin p = ar - 65536; q = ai; end
               cau_pkg::OP_ADD: begin p = ar + br; q = ai + bi; end
               cau_pkg::OP_SUB: begin p = ar - br; q = ai - bi; end
               cau_pkg::OP_SADD: begin p = ar + br; q = ai; end
               default: begin p = ar - br; q = ai; end
            endcase
            fr = fit_part(p < 0, mag_of(p));
            fi = fit_part(q < 0, mag_of(q));
         end
         cau_pkg::OP_MUL: begin
            p = ar * br - ai * bi;
            q = ai * br + ar * bi;
            fr = fit_part(p < 0, mag_of(p) >> 16);
            fi = fit_part(q < 0, mag_of(q) >> 16);
         end
         cau_pkg::OP_DIV: begin
            den = m2;
            if (den == 0) r.status = cau_pkg::ST_DIV_ZERO;
            else begin
               p = ar * br + ai * bi;
               q = br * ai - ar * bi;
               fr = fit_part(p < 0, (mag_of(p) << 16) / den);
               fi = fit_part(q < 0, (mag_of(q) << 16) / den);
            end
         end
         cau_pkg::OP_EQ: r.truth = eq;
         cau_pkg::OP_NE: r.truth = !eq;
         cau_pkg::OP_LT: r.truth = m1 < m2;
         cau_pkg::OP_LE: r.truth = (m1 < m2) || eq;
         cau_pkg::OP_GT: r.truth = m1 > m2;
         cau_pkg::OP_GE: r.truth = (m1 > m2) || eq;
         cau_pkg::OP_SMUL: begin
            fr = fit_part((ar < 0) != (br < 0), mag_of(ar * br) >> 16);
            fi = fit_part((ai < 0) != (br < 0), mag_of(ai * br) >> 16);
         end
         cau_pkg::OP_SDIV: begin
            if (br == 0) r.status = cau_pkg::ST_DIV_ZERO;
            else begin
               fr = fit_part((ar < 0) != (br < 0), (mag_of(ar) << 16) / mag_of(br));
               fi = fit_part((ai < 0) != (br < 0), (mag_of(ai) << 16) / mag_of(br));
            end
         end
         default: ;
      endcase
      r.re = fr[31:0];
      r.im = fi[31:0];
      if (r.status != cau_pkg::ST_DIV_ZERO && (fr[32] || fi[32])) r.status = cau_pkg::ST_SAT;
      return r;
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 6))
         0, 1: return $urandom();
         2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
         3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
         4: begin
            case ($urandom_range(0, 6))
               0: return 32'h7fffffff;
               1: return 32'h80000000;
               2: return 32'h00010000;
               3: return 32'hffff0000;
               4: return 32'h1;
               5: return 32'hffffffff;
               default: return 32'h0;
            endcase
         end
         5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
         default: return 32'h0;
      endcase
   endfunction

   function automatic operation_type random_op();
      operation_type t;
      t.op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                                           : 5'($urandom_range(0, 16));
      t.a_re = pick_operand(); t.a_im = pick_operand();
      t.b_re = pick_operand(); t.b_im = pick_operand();
      case ($urandom_range(0, 9))
         0: begin t.b_re = t.a_re; t.b_im = t.a_im; end
         1: begin t.b_re = t.a_im; t.b_im = -t.a_re; end   // same magnitude
         2: begin t.b_re = t.a_re; t.b_im = t.a_im ^ 32'h1; end
         3: begin t.b_re = 32'h0; t.b_im = ($urandom_range(0, 1) == 1) ? 32'h0 : t.b_im; end
         default: ;
      endcase
      return t;
   endfunction

   task automatic add_op(logic [4:0] op, logic [31:0] ar, ai, br, bi);
      operation_type t;
      t.op = op; t.a_re = ar; t.a_im = ai; t.b_re = br; t.b_im = bi;
      pending_ops.push_back(t);
   endtask

   // driver: bursts of transactions separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_type <= '0;
         req_a_re <= '0;
         req_a_im <= '0;
         req_b_re <= '0;
         req_b_im <= '0;
      end else begin
         if (start && !busy) begin
            expected_outcomes.push_back(compute_outcome(pending_ops.pop_front()));
            idle_cycles <= 0;
         end else if (!rsp_valid) begin
            idle_cycles <= idle_cycles + 1;
         end else begin
            idle_cycles <= 0;
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            start <= 1'b1;
            req_type <= pending_ops[0].op;
            req_a_re <= pending_ops[0].a_re;
            req_a_im <= pending_ops[0].a_im;
            req_b_re <= pending_ops[0].b_re;
            req_b_im <= pending_ops[0].b_im;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid) begin
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected result re=%h im=%h", $time, rsp_res_re, rsp_res_im);
            errors <= errors + 1;
         end else begin
            e = expected_outcomes.pop_front();
            if (rsp_res_re !== e.re || rsp_res_im !== e.im || rsp_truth !== e.truth ||
                rsp_status !== e.status) begin
               $display("%0t: mismatch expected re=%h im=%h truth=%b status=%0d", $time,
                        e.re, e.im, e.truth, e.status);
               $display("%0t:          actual   re=%h im=%h truth=%b status=%0d", $time,
                        rsp_res_re, rsp_res_im, rsp_truth, rsp_status);
               errors <= errors + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      for (int k = 0; k <= 16; k++)
         add_op(5'(k), 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
      add_op(cau_pkg::OP_NEG, 32'h00018000, 32'hfffe0000, 32'h0, 32'h0);
      add_op(cau_pkg::OP_DIV, 32'h00010000, 32'h00020000, 32'h0, 32'h0);
      add_op(cau_pkg::OP_SDIV, 32'h00010000, 32'h00020000, 32'h0, 32'h5);
      add_op(cau_pkg::OP_DIV, 32'h00030000, 32'h00010000, 32'h00010000, 32'hffff0000);
      add_op(cau_pkg::OP_EQ, 32'h1234, 32'h5678, 32'h1234, 32'h5678);
      add_op(cau_pkg::OP_LE, 32'h1234, 32'h5678, 32'h1234, 32'h5678);
      add_op(cau_pkg::OP_GE, 32'h00010000, 32'h0, 32'h0, 32'hffff0000);
      add_op(UNUSED_OP, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      for (int k = 0; k < 1800; k++) pending_ops.push_back(random_op());
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (pending_ops.size() == 0 && expected_outcomes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_outcomes.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
